// ----- design/nump_pkg.sv -----
package nump_pkg;

    // Field widths of the item and result words.
    localparam int COORD_W   = 25;
    localparam int NUM_W     = 15;
    localparam int MODE_W    = 2;
    localparam int TOTAL_W   = 16;
    localparam int INDEX_W   = 10;
    localparam int CUTOFF_W  = 32;

    // Squared distance datapath widths.
    localparam int ABS_W     = COORD_W;
    localparam int SQ_W      = 2 * ABS_W;
    localparam int DIST_W    = SQ_W + 2;

    localparam int MAX_REF_DEFAULT = 1024;

    localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 32'd1440000;
    localparam logic [TOTAL_W-1:0]  TOTAL_MAX    = 16'hFFFF;

    // Command codes carried in the mode field.
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // Register map of the configuration port.
    localparam int APB_ADDR_W = 2;
    localparam logic [APB_ADDR_W-1:0] ADDR_CUTOFF = 2'd0;

    typedef struct packed {
        logic load;
        logic clear;
        logic query;
        logic issue;
        logic finish;
    } nump_cmd_t;

    typedef struct packed {
        logic scan_end;
        logic pipe_busy;
    } nump_sts_t;

endpackage

// ----- design/nump_regs.sv -----
module nump_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [nump_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output logic [nump_pkg::CUTOFF_W-1:0]     cutoff
);

    logic [nump_pkg::CUTOFF_W-1:0] cutoff_reg;
    logic                          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == nump_pkg::ADDR_CUTOFF);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg <= nump_pkg::CUTOFF_RESET;
        end
        else if (wr_en)
        begin
            cutoff_reg <= pwdata;
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr == nump_pkg::ADDR_CUTOFF)
        begin
            prdata = cutoff_reg;
        end
    end

    assign cutoff = cutoff_reg;

endmodule

// ----- design/nump_ctrl.sv -----
module nump_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [nump_pkg::MODE_W-1:0]   mode,
    input  nump_pkg::nump_sts_t           sts,
    output nump_pkg::nump_cmd_t           cmd,
    output logic                          busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        busy_next  = busy_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (mode)
                        nump_pkg::MODE_LOAD:  cmd.load  = 1'b1;
                        nump_pkg::MODE_CLEAR: cmd.clear = 1'b1;
                        nump_pkg::MODE_QUERY:
                        begin
                            cmd.query  = 1'b1;
                            state_next = ST_SCAN;
                            busy_next  = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                cmd.issue = !sts.scan_end;
                if (sts.scan_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // Wait until the last entry has passed the compare stage.
                if (!sts.pipe_busy)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
                busy_next  = 1'b0;
            end
            default:
            begin
                state_next = ST_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

// ----- design/nump_dp.sv -----
module nump_dp #(
    parameter int MAX_REF = nump_pkg::MAX_REF_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  nump_pkg::nump_cmd_t                  cmd,
    output nump_pkg::nump_sts_t                  sts,
    input  logic signed [nump_pkg::COORD_W-1:0]  pos_x,
    input  logic signed [nump_pkg::COORD_W-1:0]  pos_y,
    input  logic signed [nump_pkg::COORD_W-1:0]  pos_z,
    input  logic signed [nump_pkg::NUM_W-1:0]    item_number,
    input  logic [nump_pkg::CUTOFF_W-1:0]        cutoff,
    output logic                                 done,
    output logic signed [nump_pkg::NUM_W-1:0]    echo_number,
    output logic                                 conserved,
    output logic [nump_pkg::INDEX_W-1:0]         match_index,
    output logic [nump_pkg::TOTAL_W-1:0]         conserved_total,
    output logic [nump_pkg::TOTAL_W-1:0]         displaced_total
);

    localparam int IDX_W  = (MAX_REF > 1) ? $clog2(MAX_REF) : 1;
    localparam int CNT_W  = $clog2(MAX_REF + 1);
    localparam int CW     = nump_pkg::COORD_W;
    localparam int WORD_W = 3 * CW;

    localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(MAX_REF);

    // Point table and matched flags, one read and one write port each.
    logic [WORD_W-1:0] coord_mem [MAX_REF];
    logic              flag_mem  [MAX_REF];

    logic [CNT_W-1:0]  ref_count_reg;
    logic [CNT_W-1:0]  scan_cnt_reg;

    logic [CW-1:0]     qx_reg;
    logic [CW-1:0]     qy_reg;
    logic [CW-1:0]     qz_reg;
    logic signed [nump_pkg::NUM_W-1:0] qnum_reg;

    // Stage 1: table read.
    logic              s1_valid_reg;
    logic [IDX_W-1:0]  s1_idx_reg;
    logic [WORD_W-1:0] s1_word_reg;
    logic              s1_flag_reg;
    // Stage 2: absolute differences.
    logic              s2_valid_reg;
    logic              s2_skip_reg;
    logic [IDX_W-1:0]  s2_idx_reg;
    logic [nump_pkg::ABS_W-1:0] ax_reg;
    logic [nump_pkg::ABS_W-1:0] ay_reg;
    logic [nump_pkg::ABS_W-1:0] az_reg;
    // Stage 3: squares.
    logic              s3_valid_reg;
    logic              s3_skip_reg;
    logic [IDX_W-1:0]  s3_idx_reg;
    logic [nump_pkg::SQ_W-1:0] sqx_reg;
    logic [nump_pkg::SQ_W-1:0] sqy_reg;
    logic [nump_pkg::SQ_W-1:0] sqz_reg;
    // Stage 4: distance.
    logic              s4_valid_reg;
    logic              s4_skip_reg;
    logic [IDX_W-1:0]  s4_idx_reg;
    logic [nump_pkg::DIST_W-1:0] dist_reg;

    logic              found_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [nump_pkg::DIST_W-1:0] best_d_reg;

    logic              done_reg;
    logic signed [nump_pkg::NUM_W-1:0] echo_reg;
    logic              conserved_reg;
    logic [nump_pkg::INDEX_W-1:0] index_reg;
    logic [nump_pkg::TOTAL_W-1:0] cons_cnt_reg;
    logic [nump_pkg::TOTAL_W-1:0] disp_cnt_reg;

    logic              load_ok;
    logic              hit;
    logic              flag_we;
    logic [IDX_W-1:0]  flag_addr;
    logic              flag_data;
    logic [IDX_W+nump_pkg::INDEX_W-1:0] idx_wide;

    function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] d;
        begin
            d = {a[CW-1], a} - {b[CW-1], b};
            if (d[CW])
            begin
                d = ~d + 1'b1;
            end
            abs_diff = d[CW-1:0];
        end
    endfunction

    assign load_ok = cmd.load && (ref_count_reg < CAPACITY);
    assign hit     = found_reg && (best_d_reg <= nump_pkg::DIST_W'(cutoff));

    // A load clears the flag of the new entry; a hit sets the flag of the winner.
    assign flag_we   = load_ok || (cmd.finish && hit);
    assign flag_addr = cmd.finish ? best_idx_reg : ref_count_reg[IDX_W-1:0];
    assign flag_data = cmd.finish;

    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            coord_mem[ref_count_reg[IDX_W-1:0]] <= {pos_x, pos_y, pos_z};
        end
        if (flag_we)
        begin
            flag_mem[flag_addr] <= flag_data;
        end
        if (cmd.issue)
        begin
            s1_word_reg <= coord_mem[scan_cnt_reg[IDX_W-1:0]];
            s1_flag_reg <= flag_mem[scan_cnt_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_count_reg <= '0;
            scan_cnt_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            done_reg      <= 1'b0;
            cons_cnt_reg  <= '0;
            disp_cnt_reg  <= '0;
        end
        else
        begin
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            done_reg     <= cmd.finish;

            if (cmd.clear)
            begin
                ref_count_reg <= '0;
                cons_cnt_reg  <= '0;
                disp_cnt_reg  <= '0;
            end
            else if (load_ok)
            begin
                ref_count_reg <= ref_count_reg + 1'b1;
            end

            if (cmd.query)
            begin
                scan_cnt_reg <= '0;
                found_reg    <= 1'b0;
            end
            else
            begin
                if (cmd.issue)
                begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                end
                // Strict compare keeps the lowest index on ties.
                if (s4_valid_reg && !s4_skip_reg && (!found_reg || dist_reg < best_d_reg))
                begin
                    found_reg <= 1'b1;
                end
            end

            if (cmd.finish)
            begin
                if (hit)
                begin
                    if (cons_cnt_reg != nump_pkg::TOTAL_MAX)
                    begin
                        cons_cnt_reg <= cons_cnt_reg + 1'b1;
                    end
                end
                else if (disp_cnt_reg != nump_pkg::TOTAL_MAX)
                begin
                    disp_cnt_reg <= disp_cnt_reg + 1'b1;
                end
            end
        end
    end

    assign idx_wide = {{nump_pkg::INDEX_W{1'b0}}, best_idx_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.query)
        begin
            qx_reg   <= pos_x;
            qy_reg   <= pos_y;
            qz_reg   <= pos_z;
            qnum_reg <= item_number;
        end

        s1_idx_reg  <= scan_cnt_reg[IDX_W-1:0];

        ax_reg      <= abs_diff(s1_word_reg[3*CW-1:2*CW], qx_reg);
        ay_reg      <= abs_diff(s1_word_reg[2*CW-1:CW], qy_reg);
        az_reg      <= abs_diff(s1_word_reg[CW-1:0], qz_reg);
        s2_skip_reg <= s1_flag_reg;
        s2_idx_reg  <= s1_idx_reg;

        sqx_reg     <= ax_reg * ax_reg;
        sqy_reg     <= ay_reg * ay_reg;
        sqz_reg     <= az_reg * az_reg;
        s3_skip_reg <= s2_skip_reg;
        s3_idx_reg  <= s2_idx_reg;

        dist_reg    <= nump_pkg::DIST_W'(sqx_reg) + nump_pkg::DIST_W'(sqy_reg)
                       + nump_pkg::DIST_W'(sqz_reg);
        s4_skip_reg <= s3_skip_reg;
        s4_idx_reg  <= s3_idx_reg;

        if (!cmd.query && s4_valid_reg && !s4_skip_reg
            && (!found_reg || dist_reg < best_d_reg))
        begin
            best_d_reg   <= dist_reg;
            best_idx_reg <= s4_idx_reg;
        end

        if (cmd.finish)
        begin
            echo_reg      <= qnum_reg;
            conserved_reg <= hit;
            index_reg     <= hit ? idx_wide[nump_pkg::INDEX_W-1:0] : '0;
        end
    end

    assign sts.scan_end  = (scan_cnt_reg == ref_count_reg);
    assign sts.pipe_busy = s1_valid_reg || s2_valid_reg || s3_valid_reg || s4_valid_reg;

    assign done            = done_reg;
    assign echo_number     = echo_reg;
    assign conserved       = conserved_reg;
    assign match_index     = index_reg;
    assign conserved_total = cons_cnt_reg;
    assign displaced_total = disp_cnt_reg;

endmodule

// ----- design/nearest_unmatched_point_matcher.sv -----
// Greedy nearest unmatched point matcher.
// Input words are taken at a rising edge with start high and busy low. A load
// word (mode 0) appends a point to the table if it is not full, and a clear
// word (mode 2) empties the table and zeroes both totals; each completes at
// once, raises no busy and gives no result, so they may follow one another in
// every cycle. Mode 3 is ignored. A query word (mode 1) raises busy and scans
// the stored points one per cycle through a five-stage read, difference,
// square, sum and compare pipeline. When the last point has been compared,
// done pulses for one cycle with the result, and busy is already low in that
// cycle, so the next word can be taken then. Queries do not overlap; the scan
// rate is bounded by the single read port of the point table.
// echo_number, conserved and match_index are valid in the cycle that done is
// high and hold their word until the next result; the receiver has no way to
// stall it. The cutoff register sits at byte address 0 of the APB port and may
// be changed only while the block is idle.
// Reset empties the table, zeroes the totals and sets the cutoff to 1440000.
// The table itself is not cleared; the entry count guards every read.
module nearest_unmatched_point_matcher #(
    parameter int MAX_REF = nump_pkg::MAX_REF_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [nump_pkg::MODE_W-1:0]          mode,
    input  logic signed [nump_pkg::COORD_W-1:0]  pos_x,
    input  logic signed [nump_pkg::COORD_W-1:0]  pos_y,
    input  logic signed [nump_pkg::COORD_W-1:0]  pos_z,
    input  logic signed [nump_pkg::NUM_W-1:0]    item_number,
    output logic                                 done,
    output logic signed [nump_pkg::NUM_W-1:0]    echo_number,
    output logic                                 conserved,
    output logic [nump_pkg::INDEX_W-1:0]         match_index,
    output logic [nump_pkg::TOTAL_W-1:0]         conserved_total,
    output logic [nump_pkg::TOTAL_W-1:0]         displaced_total,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [nump_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    nump_pkg::nump_cmd_t           cmd;
    nump_pkg::nump_sts_t           sts;
    logic [nump_pkg::CUTOFF_W-1:0] cutoff;

    nump_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cutoff  (cutoff)
    );

    nump_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    nump_dp #(
        .MAX_REF (MAX_REF)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .pos_z           (pos_z),
        .item_number     (item_number),
        .cutoff          (cutoff),
        .done            (done),
        .echo_number     (echo_number),
        .conserved       (conserved),
        .match_index     (match_index),
        .conserved_total (conserved_total),
        .displaced_total (displaced_total)
    );

endmodule

// ----- design/nump_checker.sv -----
module nump_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic [nump_pkg::MODE_W-1:0]         mode,
    input logic                                done,
    input logic                                conserved,
    input logic [nump_pkg::INDEX_W-1:0]        match_index,
    input logic [nump_pkg::TOTAL_W-1:0]        conserved_total
);

    // A result word ends every query and nothing else.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $fell(busy))
        else $error("result word without the end of a query");

    assert property (@(posedge clk) disable iff (!rst_n) $fell(busy) |-> done)
        else $error("query ended without a result word");

    // A query word starts a scan.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == nump_pkg::MODE_QUERY) |=> busy)
        else $error("query word did not start a scan");

    // Load, clear and unused words complete at once and give no result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode != nump_pkg::MODE_QUERY) |=> (!busy && !done))
        else $error("non-query word held the block or gave a result");

    // A conserved result has been counted; a displaced one points at entry zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (conserved ? (conserved_total != '0) : (match_index == '0)))
        else $error("result word inconsistent with its outcome");

endmodule

bind nearest_unmatched_point_matcher nump_checker u_nump_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .mode            (mode),
    .done            (done),
    .conserved       (conserved),
    .match_index     (match_index),
    .conserved_total (conserved_total)
);
